/* rtl/core/eir_pkg.sv */
// ----------------------------------------------------------------------------
// eir_pkg
// Shared types and constants for the excluded index remapper: payload
// structs, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package eir_pkg;

   localparam int INDEX_BITS = 30;
   localparam int RANGE_BITS = INDEX_BITS + 1;

   // largest range a write may set, and the range after reset
   localparam logic [RANGE_BITS-1:0] RANGE_MAX   = {1'b1, {INDEX_BITS{1'b0}}};
   localparam logic [RANGE_BITS-1:0] RANGE_RESET = RANGE_BITS'(1024);

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_ADD   = 2'd1,
      FUNC_BUILD = 2'd2,
      FUNC_PICK  = 2'd3
   } eir_func_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_IGNORED = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_REJECT  = 2'd3
   } eir_status_type;

   // where the picked index of a response comes from
   typedef enum logic [1:0] {
      SRC_ZERO    = 2'd0,
      SRC_OPERAND = 2'd1,
      SRC_TARGET  = 2'd2
   } eir_src_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DUP_RD,
      ST_DUP_CMP,
      ST_ADD_END,
      ST_CNT_RD,
      ST_CNT_CMP,
      ST_OUT_RD,
      ST_OUT_CMP,
      ST_TAIL_CHK,
      ST_TAIL_RD,
      ST_TAIL_CMP,
      ST_PICK_RD,
      ST_PICK_CMP,
      ST_TGT_WAIT,
      ST_RESP
   } eir_state_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [INDEX_BITS-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] picked_index;
      logic [RANGE_BITS-1:0] live_count;
      logic [1:0]            status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic           load_req;
      logic           scan_clr;
      logic           scan_inc;
      logic           outer_clr;
      logic           outer_inc;
      logic           rd_key;
      logic           rd_key_outer;
      logic           rd_target;
      logic           live_clr;
      logic           live_inc;
      logic           set_allowed;
      logic           tail_dec;
      logic           wr_target;
      logic           add_key;
      logic           clear_tbl;
      logic           set_built;
      logic           set_res;
      eir_status_type res_status;
      eir_src_type    res_src;
      logic           rsp_load;
   } eir_cmd_type;

   // datapath to controller
   typedef struct packed {
      eir_func_type func;
      logic         scan_done;
      logic         outer_done;
      logic         key_eq_opv;
      logic         key_below_range;
      logic         key_below_allowed;
      logic         key_eq_tail;
      logic         tail_zero;
      logic         opv_ge_range;
      logic         table_full;
      logic         pick_ok;
      logic         rsp_free;
   } eir_sts_type;

endpackage

/* rtl/core/excluded_index_remapper.sv */
// ----------------------------------------------------------------------------
// excluded_index_remapper
// Keeps a table of up to TABLE_DEPTH excluded indices and maps a uniform draw
// below the live count onto the allowed part of [0, range_size). One request
// is worked at a time; a response waits in an output register while the next
// request is taken. With N stored entries, every table lookup walks the key
// memory through its single read port one entry at a time, and the build
// repeats that walk for each tail slot it checks, of which there are at most N.
// ----------------------------------------------------------------------------
module excluded_index_remapper
   import eir_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [RANGE_BITS-1:0] csr_wr_data
);

   eir_cmd_type cmd;
   eir_sts_type sts;

   // sequencer
   eir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, registers and response buffer
   eir_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

/* rtl/core/eir_datapath.sv */
// ----------------------------------------------------------------------------
// eir_datapath
// Range and count registers, key and target memories with registered reads,
// scan counters, compare flags and the response register.
// ----------------------------------------------------------------------------
module eir_datapath
   import eir_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [RANGE_BITS-1:0] csr_wr_data,
   input  eir_cmd_type cmd,
   output eir_sts_type sts
);

   localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

   logic [RANGE_BITS-1:0] range_ff, range_in;
   logic [RANGE_BITS-1:0] allowed_ff, allowed_in;
   logic [RANGE_BITS-1:0] tail_ff, tail_in;
   logic                  built_ff, built_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   live_ff, live_in;
   logic [CNT_BITS-1:0]   outer_ff, outer_in;
   logic [CNT_BITS-1:0]   scan_ff, scan_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            func_ff;
   logic [INDEX_BITS-1:0] opv_ff;
   logic [INDEX_BITS-1:0] key_rd_ff;
   logic [INDEX_BITS-1:0] tgt_rd_ff;
   logic [INDEX_BITS-1:0] res_pick_ff, res_pick_in;
   eir_status_type        res_status_ff;
   rsp_type               rsp_data_ff;

   logic [INDEX_BITS-1:0] key_mem [0:TABLE_DEPTH-1];
   logic [INDEX_BITS-1:0] target_mem [0:TABLE_DEPTH-1];

   logic [RANGE_BITS-1:0] tail_minus_one;
   logic [ADDR_BITS-1:0]  key_addr;

   assign tail_minus_one = tail_ff - RANGE_BITS'(1);
   assign key_addr = cmd.rd_key_outer ? outer_ff[ADDR_BITS-1:0] : scan_ff[ADDR_BITS-1:0];

   // next values of the control registers
   always_comb begin
      range_in = range_ff;
      if (csr_wr_en) begin
         range_in = (csr_wr_data > RANGE_MAX) ? RANGE_MAX : csr_wr_data;
      end

      built_in = built_ff;
      if (csr_wr_en || cmd.clear_tbl || cmd.add_key) begin
         built_in = 1'b0;
      end else if (cmd.set_built) begin
         built_in = 1'b1;
      end

      count_in = count_ff;
      if (cmd.clear_tbl) begin
         count_in = '0;
      end else if (cmd.add_key) begin
         count_in = count_ff + CNT_BITS'(1);
      end

      allowed_in = allowed_ff;
      if (cmd.set_allowed) begin
         allowed_in = range_ff - RANGE_BITS'(live_ff);
      end

      tail_in = tail_ff;
      if (cmd.set_allowed) begin
         tail_in = range_ff;
      end else if (cmd.tail_dec || (cmd.wr_target && !sts.tail_zero)) begin
         tail_in = tail_minus_one;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // next values of the scan counters
   always_comb begin
      live_in = live_ff;
      if (cmd.live_clr) begin
         live_in = '0;
      end else if (cmd.live_inc) begin
         live_in = live_ff + CNT_BITS'(1);
      end

      outer_in = outer_ff;
      if (cmd.outer_clr) begin
         outer_in = '0;
      end else if (cmd.outer_inc) begin
         outer_in = outer_ff + CNT_BITS'(1);
      end

      scan_in = scan_ff;
      if (cmd.scan_clr) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + CNT_BITS'(1);
      end
   end

   // picked index source for the pending response
   always_comb begin
      case (cmd.res_src)
         SRC_OPERAND: res_pick_in = opv_ff;
         SRC_TARGET:  res_pick_in = tgt_rd_ff;
         default:     res_pick_in = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff     <= RANGE_RESET;
         built_ff     <= 1'b0;
         count_ff     <= '0;
         allowed_ff   <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         range_ff     <= range_in;
         built_ff     <= built_in;
         count_ff     <= count_in;
         allowed_ff   <= allowed_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // counters and payload registers
   always_ff @(posedge clock) begin
      live_ff  <= live_in;
      outer_ff <= outer_in;
      scan_ff  <= scan_in;
      if (cmd.load_req) begin
         func_ff <= req_data.func;
         opv_ff  <= req_data.operand_value;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_pick_ff   <= res_pick_in;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.picked_index <= res_pick_ff;
         rsp_data_ff.live_count   <= allowed_ff;
         rsp_data_ff.status       <= 2'(res_status_ff);
      end
   end

   // key memory: written on add, read by the scans
   always_ff @(posedge clock) begin
      if (cmd.add_key) begin
         key_mem[count_ff[ADDR_BITS-1:0]] <= opv_ff;
      end
      if (cmd.rd_key) begin
         key_rd_ff <= key_mem[key_addr];
      end
   end

   // target memory: written by build, read by pick
   always_ff @(posedge clock) begin
      if (cmd.wr_target) begin
         target_mem[outer_ff[ADDR_BITS-1:0]] <=
            sts.tail_zero ? '0 : tail_minus_one[INDEX_BITS-1:0];
      end
      if (cmd.rd_target) begin
         tgt_rd_ff <= target_mem[scan_ff[ADDR_BITS-1:0]];
      end
   end

   // status flags
   always_comb begin
      sts.func              = eir_func_type'(func_ff);
      sts.scan_done         = (scan_ff >= count_ff);
      sts.outer_done        = (outer_ff >= count_ff);
      sts.key_eq_opv        = (key_rd_ff == opv_ff);
      sts.key_below_range   = ({1'b0, key_rd_ff} < range_ff);
      sts.key_below_allowed = ({1'b0, key_rd_ff} < allowed_ff);
      sts.tail_zero         = (tail_ff == '0);
      sts.key_eq_tail       = !sts.tail_zero && ({1'b0, key_rd_ff} == tail_minus_one);
      sts.opv_ge_range      = ({1'b0, opv_ff} >= range_ff);
      sts.table_full        = (count_ff >= DEPTH_CNT);
      sts.pick_ok           = built_ff && ({1'b0, opv_ff} < allowed_ff);
      sts.rsp_free          = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count exceeds table depth");

   a_scan_read_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_key && !cmd.rd_key_outer |-> scan_ff < count_ff)
      else $error("key read beyond stored entries");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("waiting response dropped or changed");
`endif

endmodule

/* rtl/core/eir_ctrl.sv */
// ----------------------------------------------------------------------------
// eir_ctrl
// Sequencer for one request at a time: decodes the operation, steps the
// table scans and the tail walk of a build, and hands off the response.
// ----------------------------------------------------------------------------
module eir_ctrl
   import eir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  eir_sts_type sts,
   output eir_cmd_type cmd
);

   eir_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (sts.func)
               FUNC_CLEAR: state_in = ST_RESP;
               FUNC_ADD:   state_in = sts.opv_ge_range ? ST_RESP : ST_DUP_RD;
               FUNC_BUILD: state_in = ST_CNT_RD;
               FUNC_PICK:  state_in = sts.pick_ok ? ST_PICK_RD : ST_RESP;
            endcase
         end
         ST_DUP_RD:   state_in = sts.scan_done ? ST_ADD_END : ST_DUP_CMP;
         ST_DUP_CMP:  state_in = sts.key_eq_opv ? ST_RESP : ST_DUP_RD;
         ST_ADD_END:  state_in = ST_RESP;
         ST_CNT_RD:   state_in = sts.scan_done ? ST_OUT_RD : ST_CNT_CMP;
         ST_CNT_CMP:  state_in = ST_CNT_RD;
         ST_OUT_RD:   state_in = sts.outer_done ? ST_RESP : ST_OUT_CMP;
         ST_OUT_CMP:  state_in = sts.key_below_allowed ? ST_TAIL_CHK : ST_OUT_RD;
         ST_TAIL_CHK: state_in = sts.tail_zero ? ST_OUT_RD : ST_TAIL_RD;
         ST_TAIL_RD:  state_in = sts.scan_done ? ST_OUT_RD : ST_TAIL_CMP;
         ST_TAIL_CMP: state_in = sts.key_eq_tail ? ST_TAIL_CHK : ST_TAIL_RD;
         ST_PICK_RD:  state_in = sts.scan_done ? ST_RESP : ST_PICK_CMP;
         ST_PICK_CMP: state_in = sts.key_eq_opv ? ST_TGT_WAIT : ST_PICK_RD;
         ST_TGT_WAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.res_status = STAT_OK;
      cmd.res_src    = SRC_ZERO;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_DECODE: begin
            unique case (sts.func)
               FUNC_CLEAR: begin
                  cmd.clear_tbl = 1'b1;
                  cmd.set_res   = 1'b1;
               end
               FUNC_ADD: begin
                  cmd.scan_clr = 1'b1;
                  if (sts.opv_ge_range) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = STAT_IGNORED;
                  end
               end
               FUNC_BUILD: begin
                  cmd.scan_clr = 1'b1;
                  cmd.live_clr = 1'b1;
               end
               FUNC_PICK: begin
                  cmd.scan_clr = 1'b1;
                  if (!sts.pick_ok) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = STAT_REJECT;
                  end
               end
            endcase
         end
         // duplicate search over all stored entries
         ST_DUP_RD: begin
            cmd.rd_key = !sts.scan_done;
         end
         ST_DUP_CMP: begin
            if (sts.key_eq_opv) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = STAT_IGNORED;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ST_ADD_END: begin
            cmd.set_res = 1'b1;
            if (sts.table_full) begin
               cmd.res_status = STAT_FULL;
            end else begin
               cmd.add_key = 1'b1;
            end
         end
         // count entries inside the range
         ST_CNT_RD: begin
            if (sts.scan_done) begin
               cmd.set_allowed = 1'b1;
               cmd.outer_clr   = 1'b1;
            end else begin
               cmd.rd_key = 1'b1;
            end
         end
         ST_CNT_CMP: begin
            cmd.live_inc = sts.key_below_range;
            cmd.scan_inc = 1'b1;
         end
         // walk entries in load order, remap those below the live count
         ST_OUT_RD: begin
            if (sts.outer_done) begin
               cmd.set_built = 1'b1;
               cmd.set_res   = 1'b1;
            end else begin
               cmd.rd_key       = 1'b1;
               cmd.rd_key_outer = 1'b1;
            end
         end
         ST_OUT_CMP: begin
            cmd.outer_inc = !sts.key_below_allowed;
         end
         ST_TAIL_CHK: begin
            if (sts.tail_zero) begin
               cmd.wr_target = 1'b1;
               cmd.outer_inc = 1'b1;
            end else begin
               cmd.scan_clr = 1'b1;
            end
         end
         // is the tail slot itself excluded
         ST_TAIL_RD: begin
            if (sts.scan_done) begin
               cmd.wr_target = 1'b1;
               cmd.outer_inc = 1'b1;
            end else begin
               cmd.rd_key = 1'b1;
            end
         end
         ST_TAIL_CMP: begin
            if (sts.key_eq_tail) begin
               cmd.tail_dec = 1'b1;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         // pick lookup
         ST_PICK_RD: begin
            if (sts.scan_done) begin
               cmd.set_res = 1'b1;
               cmd.res_src = SRC_OPERAND;
            end else begin
               cmd.rd_key = 1'b1;
            end
         end
         ST_PICK_CMP: begin
            if (sts.key_eq_opv) begin
               cmd.rd_target = 1'b1;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ST_TGT_WAIT: begin
            cmd.set_res = 1'b1;
            cmd.res_src = SRC_TARGET;
         end
         ST_RESP: begin
            cmd.rsp_load = sts.rsp_free;
         end
         default: begin
            cmd.res_src = SRC_ZERO;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response loaded over an unread response");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

   a_target_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_target |-> !sts.outer_done)
      else $error("target written beyond stored entries");
`endif

endmodule

/* sim/excluded_index_remapper_test.sv */
// ----------------------------------------------------------------------------
// excluded_index_remapper_test
// Self-checking bench for the excluded index remapper. A table of directed
// requests covers the corner cases first. Random clear/add/build/pick
// sequences follow under several range settings and idle patterns. Every
// response is checked field by field against its typed directed result or an
// in-bench mirror of the exclusion table and its remap targets.
// ----------------------------------------------------------------------------
module excluded_index_remapper_test;
   import eir_pkg::*;

   localparam int TABLE_DEPTH     = 64;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int HOLD_CYCLES     = 400;
   localparam int SETTLE_CYCLES   = 200;
   localparam int RANDOM_REQUESTS = 500;
   localparam int PHASES          = 8;
   localparam int DIRECTED_COUNT  = 30;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [RANGE_BITS-1:0] csr_value;
      eir_func_type          func;
      logic [INDEX_BITS-1:0] operand;
      logic                  typed;
      rsp_type               result;
   } directed_row_type;

   // directed corner cases, expected result typed in where it is obvious
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd0, 1'b1, '{30'd0, 31'd0, STAT_REJECT}},
      '{ROW_REQ, 31'd0, FUNC_BUILD, 30'd0, 1'b1, '{30'd0, 31'd1024, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd1023, 1'b1, '{30'd1023, 31'd1024, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd1024, 1'b1, '{30'd0, 31'd1024, STAT_REJECT}},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'd1023, 1'b1, '{30'd0, 31'd1024, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'd1023, 1'b1, '{30'd0, 31'd1024, STAT_IGNORED}},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'd1024, 1'b1, '{30'd0, 31'd1024, STAT_IGNORED}},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'h3FFFFFFF, 1'b1,
        '{30'd0, 31'd1024, STAT_IGNORED}},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'd0, 1'b1, '{30'd0, 31'd1024, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'd5, 1'b1, '{30'd0, 31'd1024, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd3, 1'b1, '{30'd0, 31'd1024, STAT_REJECT}},
      '{ROW_REQ, 31'd0, FUNC_BUILD, 30'd0, 1'b1, '{30'd0, 31'd1021, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd0, 1'b0, '0},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd5, 1'b0, '0},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd1020, 1'b1, '{30'd1020, 31'd1021, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd1021, 1'b1, '{30'd0, 31'd1021, STAT_REJECT}},
      '{ROW_REQ, 31'd0, FUNC_CLEAR, 30'd0, 1'b1, '{30'd0, 31'd1021, STAT_OK}},
      '{ROW_CSR, 31'd0, FUNC_CLEAR, 30'd0, 1'b0, '0},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'd0, 1'b1, '{30'd0, 31'd1021, STAT_IGNORED}},
      '{ROW_REQ, 31'd0, FUNC_BUILD, 30'd0, 1'b1, '{30'd0, 31'd0, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd0, 1'b1, '{30'd0, 31'd0, STAT_REJECT}},
      '{ROW_CSR, 31'h7FFFFFFF, FUNC_CLEAR, 30'd0, 1'b0, '0},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'h3FFFFFFF, 1'b1, '{30'd0, 31'd0, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_ADD, 30'd0, 1'b1, '{30'd0, 31'd0, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_BUILD, 30'd0, 1'b1, '{30'd0, 31'h3FFFFFFE, STAT_OK}},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd0, 1'b0, '0},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'h3FFFFFFE, 1'b1,
        '{30'd0, 31'h3FFFFFFE, STAT_REJECT}},
      '{ROW_CSR, 31'd1, FUNC_CLEAR, 30'd0, 1'b0, '0},
      '{ROW_REQ, 31'd0, FUNC_PICK, 30'd0, 1'b1, '{30'd0, 31'h3FFFFFFE, STAT_REJECT}},
      '{ROW_REQ, 31'd0, FUNC_BUILD, 30'd0, 1'b1, '{30'd0, 31'd0, STAT_OK}}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [RANGE_BITS-1:0] csr_wr_data = '0;

   // mirror of the block state
   logic [RANGE_BITS-1:0] mirror_range   = RANGE_RESET;
   logic [INDEX_BITS-1:0] mirror_keys    [TABLE_DEPTH];
   logic [INDEX_BITS-1:0] mirror_targets [TABLE_DEPTH];
   int                    mirror_count   = 0;
   logic [RANGE_BITS-1:0] mirror_allowed = '0;
   logic                  mirror_built   = 1'b0;

   rsp_type pending_responses [$];

   int   failures           = 0;
   int   checked            = 0;
   int   sent_count         = 0;
   int   range_writes       = 0;
   int   cycle_count        = 0;
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   logic hold_armed         = 1'b0;
   int   hold_left          = HOLD_CYCLES;

   excluded_index_remapper #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // position of a stored key below limit, or -1
   function automatic int find_stored_key(input longint value, input longint limit);
      for (int i = 0; i < mirror_count; i++) begin
         if (mirror_keys[i] < limit && mirror_keys[i] == value) return i;
      end
      return -1;
   endfunction

   // live count, then hand each low excluded key the highest free tail index
   function automatic void rebuild_remap();
      longint live;
      longint tail;
      live = 0;
      for (int i = 0; i < mirror_count; i++) begin
         if (mirror_keys[i] < mirror_range) live++;
      end
      mirror_allowed = RANGE_BITS'(mirror_range - live);
      tail = mirror_range;
      for (int i = 0; i < mirror_count; i++) begin
         if (mirror_keys[i] < mirror_allowed) begin
            while (tail > 0 && find_stored_key(tail - 1, mirror_range) >= 0) tail--;
            if (tail > 0) begin
               mirror_targets[i] = INDEX_BITS'(tail - 1);
               tail--;
            end else begin
               mirror_targets[i] = '0;
            end
         end
      end
      mirror_built = 1'b1;
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type res;
      int      pos;
      res = '0;
      case (r.func)
         FUNC_CLEAR: begin
            mirror_count = 0;
            mirror_built = 1'b0;
         end
         FUNC_ADD: begin
            // range check, then duplicate, then full
            if (r.operand_value >= mirror_range ||
                find_stored_key(r.operand_value, longint'(RANGE_MAX) + 1) >= 0) begin
               res.status = STAT_IGNORED;
            end else if (mirror_count >= TABLE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               mirror_keys[mirror_count] = r.operand_value;
               mirror_count++;
               mirror_built = 1'b0;
            end
         end
         FUNC_BUILD: begin
            rebuild_remap();
         end
         FUNC_PICK: begin
            if (!mirror_built || r.operand_value >= mirror_allowed) begin
               res.status = STAT_REJECT;
            end else begin
               pos = find_stored_key(r.operand_value, mirror_allowed);
               res.picked_index = pos >= 0 ? mirror_targets[pos] : r.operand_value;
            end
         end
      endcase
      res.live_count = mirror_allowed;
      return res;
   endfunction

   // key for an add: mostly in range, biased to the tail and to repeats
   function automatic logic [INDEX_BITS-1:0] random_key();
      int unsigned dice;
      longint      span;
      dice = $urandom_range(99);
      if (mirror_range == 0 || dice >= 92) return INDEX_BITS'($urandom);
      if (dice < 35) begin
         span = mirror_range - 1 < 15 ? mirror_range - 1 : 15;
         return INDEX_BITS'(mirror_range - 1 - $urandom_range(span));
      end
      if (dice < 50 && mirror_count > 0)
         return mirror_keys[$urandom_range(mirror_count - 1)];
      return INDEX_BITS'($urandom_range(mirror_range - 1));
   endfunction

   // draw for a pick: excluded keys, plain draws, the live count edge, noise
   function automatic logic [INDEX_BITS-1:0] random_draw();
      int unsigned dice;
      longint      live;
      dice = $urandom_range(99);
      live = mirror_built ? mirror_allowed : mirror_range;
      if (dice < 35 && mirror_count > 0)
         return mirror_keys[$urandom_range(mirror_count - 1)];
      if (dice < 75 && live > 0) return INDEX_BITS'($urandom_range(live - 1));
      if (dice < 85) return INDEX_BITS'(live - $urandom_range(1));
      return INDEX_BITS'($urandom);
   endfunction

   // offer one request, record its expected response once accepted
   task automatic send_request(input eir_func_type func,
                               input logic [INDEX_BITS-1:0] operand,
                               input logic typed, input rsp_type typed_result);
      req_type item;
      rsp_type want;
      item.func          = func;
      item.operand_value = operand;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      want = predict_response(item);
      if (typed) want = typed_result;
      pending_responses.push_back(want);
      sent_count++;
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_range(input logic [RANGE_BITS-1:0] value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror_range = value > RANGE_MAX ? RANGE_MAX : value;
      mirror_built = 1'b0;
      range_writes++;
   endtask

   // clear, load some keys, build, then pick
   task automatic run_episode(input int adds, input int picks);
      send_request(FUNC_CLEAR, INDEX_BITS'($urandom), 1'b0, '0);
      repeat (adds) send_request(FUNC_ADD, random_key(), 1'b0, '0);
      send_request(FUNC_BUILD, INDEX_BITS'($urandom), 1'b0, '0);
      repeat (picks) send_request(FUNC_PICK, random_draw(), 1'b0, '0);
   endtask

   // response side: long hold-off once armed, else random stalls
   always @(posedge clock) begin
      if (hold_armed && hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            failures++;
            $error("response with no request outstanding");
         end else begin
            want = pending_responses.pop_front();
            checked++;
            if (rsp_data.picked_index !== want.picked_index) begin
               failures++;
               $error("picked_index expected %0d got %0d",
                      want.picked_index, rsp_data.picked_index);
            end
            if (rsp_data.live_count !== want.live_count) begin
               failures++;
               $error("live_count expected %0d got %0d",
                      want.live_count, rsp_data.live_count);
            end
            if (rsp_data.status !== want.status) begin
               failures++;
               $error("field status expected %0d got %0d",
                      want.status, rsp_data.status);
            end
         end
      end
   end

   initial begin : stimulus
      int                    directed_sent;
      int unsigned           dice;
      logic [RANGE_BITS-1:0] phase_range;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR) begin
            set_range(DIRECTED_ROWS[i].csr_value);
         end else begin
            send_request(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].operand,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
         end
      end
      directed_sent = sent_count;

      // random phases over range settings and idle patterns
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       phase_range = RANGE_BITS'(1024);
            1:       phase_range = RANGE_BITS'(64);
            2:       phase_range = 31'h7FFFFFFF;
            3:       phase_range = RANGE_BITS'(1);
            4:       phase_range = '0;
            5:       phase_range = RANGE_BITS'($urandom_range(2, 300));
            6:       phase_range = RANGE_MAX;
            default: phase_range = RANGE_BITS'($urandom_range(301, 1 << 20));
         endcase
         set_range(phase_range);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
            default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
         endcase

         if (p == 0) begin
            // long response hold-off while the table is filled to the brim
            hold_armed <= 1'b1;
            send_request(FUNC_CLEAR, '0, 1'b0, '0);
            for (int i = 0; i < TABLE_DEPTH; i++)
               send_request(FUNC_ADD, INDEX_BITS'(16 * i + $urandom_range(15)), 1'b0, '0);
            repeat (4) send_request(FUNC_ADD, random_key(), 1'b0, '0);
            send_request(FUNC_BUILD, '0, 1'b0, '0);
            repeat (8) send_request(FUNC_PICK, random_draw(), 1'b0, '0);
         end

         // table left from the previous range, rebuilt under the new one
         send_request(FUNC_BUILD, INDEX_BITS'($urandom), 1'b0, '0);
         repeat (3) send_request(FUNC_PICK, random_draw(), 1'b0, '0);

         while (sent_count - directed_sent < (p + 1) * RANDOM_REQUESTS / PHASES) begin
            dice = $urandom_range(99);
            if (dice < 15) begin
               // noise: any operation, any operand
               repeat (5) send_request(eir_func_type'($urandom_range(3)),
                                       INDEX_BITS'($urandom), 1'b0, '0);
            end else if (dice < 85) begin
               run_episode($urandom_range(0, 8), $urandom_range(3, 10));
            end else if (dice < 97) begin
               run_episode($urandom_range(9, 30), $urandom_range(3, 10));
            end else begin
               run_episode($urandom_range(60, 70), $urandom_range(3, 10));
            end
         end
      end

      // wind down
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0) begin
         failures++;
         $error("%0d responses never arrived", pending_responses.size());
      end

      $display("%0d requests (%0d directed), %0d responses checked, %0d failures",
               sent_count, directed_sent, checked, failures);
      $display("%0d range writes incl. zero, one and saturating, four idle patterns",
               range_writes);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
